// ----- sv/miller_rabin_prime_test_macros.svh -----
// Assertion shorthands shared by the RTL.
`ifndef MILLER_RABIN_PRIME_TEST_MACROS_SVH
`define MILLER_RABIN_PRIME_TEST_MACROS_SVH

// Same-cycle implication.
`define MRPT_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mrpt assertion failed");

// Next-cycle implication.
`define MRPT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mrpt assertion failed");

`endif

// ----- sv/mrpt_pkg.sv -----
package mrpt_pkg;

   localparam int WIDTH   = 31;
   localparam int FIELD_W = 31;
   localparam int CNT_W   = $clog2(WIDTH + 1);
   localparam int SH_W    = $clog2(WIDTH);
   localparam int QDEPTH  = 2;
   localparam int QPTR_W  = $clog2(QDEPTH);

   typedef logic [WIDTH-1:0] word_type;

   typedef enum logic [1:0] {
      K_PRIME,
      K_COMP,
      K_TEST
   } kind_type;

   typedef struct packed {
      kind_type kind;
      word_type cand;
      word_type base;
      logic     last;
   } item_type;

   typedef struct packed {
      logic     start;
      word_type x;
      word_type y;
      word_type p;
   } mm_cmd_type;

   typedef struct packed {
      logic     done;
      word_type result;
   } mm_rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SHIFT,
      S_REDUCE,
      S_POW,
      S_POW_MUL,
      S_POW_SQ,
      S_CHK,
      S_CHK_LOOP,
      S_CHK_SQ,
      S_FIN
   } state_type;

endpackage

// ----- sv/mrpt_req_if.sv -----
interface mrpt_req_if import mrpt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] candidate;
   logic [FIELD_W-1:0] base;
   logic               last_base;

   modport source (output valid, candidate, base, last_base, input ready);
   modport sink   (input valid, candidate, base, last_base, output ready);
endinterface

// ----- sv/mrpt_rsp_if.sv -----
interface mrpt_rsp_if import mrpt_pkg::*; ();
   logic valid;
   logic ready;
   logic probably_prime;

   modport source (output valid, probably_prime, input ready);
   modport sink   (input valid, probably_prime, output ready);
endinterface

// ----- sv/miller_rabin_prime_test.sv -----
// Miller-Rabin test, one base per req beat; a rsp beat follows only the beat
// marked last_base and carries the verdict over all bases of the run. Two
// beats queue ahead of the tester. Candidate two, even candidates, zero and one
// skip the test. An odd candidate first has d found by shifting, then takes one
// reduction, up to two modular products per bit of d and up to b squarings, all
// on the one shift-add modular multiplier, with a decision step per bit of d or
// per squaring.
module miller_rabin_prime_test import mrpt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   mrpt_req_if.sink   req,
   mrpt_rsp_if.source rsp
);

   logic     push_valid, push_ready;
   item_type push_item;
   logic     pop_valid, pop_ready;
   item_type pop_item;

   mrpt_front u_front (
      .req        (req),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   mrpt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   mrpt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_item  (pop_item),
      .pop_ready (pop_ready),
      .rsp       (rsp)
   );

endmodule

// ----- sv/mrpt_front.sv -----
module mrpt_front import mrpt_pkg::*; (
   mrpt_req_if.sink  req,
   output logic      push_valid,
   output item_type  push_item,
   input  logic      push_ready
);

   word_type p;

   always_comb begin
      p                = req.candidate[WIDTH-1:0];
      push_valid       = req.valid;
      req.ready        = push_ready;
      push_item.cand   = p;
      push_item.base   = req.base[WIDTH-1:0];
      push_item.last   = req.last_base;
      if (p == word_type'(2)) begin
         push_item.kind = K_PRIME;
      end else if (!p[0] || p == word_type'(1)) begin
         push_item.kind = K_COMP;
      end else begin
         push_item.kind = K_TEST;
      end
   end

endmodule

// ----- sv/mrpt_queue.sv -----
module mrpt_queue import mrpt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   input  item_type push_item,
   output logic     push_ready,
   output logic     pop_valid,
   output item_type pop_item,
   input  logic     pop_ready
);

   item_type          mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              push, pop;

   always_comb begin
      push_ready = count_ff != (QPTR_W+1)'(QDEPTH);
      pop_valid  = count_ff != '0;
      pop_item   = mem_ff[rd_ptr_ff];
      push       = push_valid && push_ready;
      pop        = pop_valid && pop_ready;
      wr_ptr_in  = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in  = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in   = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- sv/mrpt_modmul.sv -----
`include "miller_rabin_prime_test_macros.svh"

module mrpt_modmul import mrpt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  mm_cmd_type cmd,
   output mm_rsp_type rsp
);

   word_type         acc_ff, acc_in;
   word_type         x_ff, x_in;
   word_type         y_ff, y_in;
   word_type         p_ff, p_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [WIDTH:0]   dbl, dbl_red, sum, sum_red;

   always_comb begin
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, p_ff}) ? dbl - {1'b0, p_ff} : dbl;
      sum     = dbl_red + (y_ff[WIDTH-1] ? {1'b0, x_ff} : '0);
      sum_red = (sum >= {1'b0, p_ff}) ? sum - {1'b0, p_ff} : sum;

      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      p_in    = p_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         acc_in = sum_red[WIDTH-1:0];
         y_in   = {y_ff[WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (cmd.start) begin
         acc_in  = '0;
         x_in    = cmd.x;
         y_in    = cmd.y;
         p_in    = cmd.p;
         cnt_in  = CNT_W'(WIDTH);
         busy_in = 1'b1;
      end
      rsp.done   = done_ff;
      rsp.result = acc_ff;
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      p_ff   <= p_in;
      cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   `MRPT_ASSERT_IMPL(a_start_idle, clock, reset, cmd.start, !busy_ff)
   `MRPT_ASSERT_IMPL(a_result_reduced, clock, reset, done_ff, acc_ff < p_ff)

endmodule

// ----- sv/mrpt_back.sv -----
`include "miller_rabin_prime_test_macros.svh"

module mrpt_back import mrpt_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      pop_valid,
   input  item_type  pop_item,
   output logic      pop_ready,
   mrpt_rsp_if.source rsp
);

   state_type        state_ff, state_in;
   item_type         item_ff, item_in;
   word_type         d_ff, d_in;
   logic [SH_W-1:0]  b_ff, b_in;
   word_type         base_ff, base_in;
   word_type         acc_ff, acc_in;
   word_type         e_ff, e_in;
   logic             wit_ff, wit_in;
   logic             flag_ff, flag_in;
   logic             wait_ff, wait_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_pp_ff, rsp_pp_in;
   logic             mul_done, out_free, rsp_load;
   logic             mul_state;
   word_type         p;
   mm_cmd_type       mm_cmd;
   mm_rsp_type       mm_rsp;

   mrpt_modmul u_modmul (
      .clock (clock),
      .reset (reset),
      .cmd   (mm_cmd),
      .rsp   (mm_rsp)
   );

   assign p         = item_ff.cand;
   assign mul_done  = wait_ff && mm_rsp.done;
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign mul_state = state_ff == S_REDUCE || state_ff == S_POW_MUL ||
                      state_ff == S_POW_SQ || state_ff == S_CHK_SQ;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (pop_valid) begin
               state_in = (pop_item.kind == K_TEST) ? S_SHIFT : S_FIN;
            end
         end
         S_SHIFT: begin
            if (d_ff[0]) begin
               state_in = S_REDUCE;
            end
         end
         S_REDUCE: begin
            if (mul_done) begin
               state_in = S_POW;
            end
         end
         S_POW: begin
            if (e_ff == '0) begin
               state_in = S_CHK;
            end else if (e_ff[0]) begin
               state_in = S_POW_MUL;
            end else begin
               state_in = S_POW_SQ;
            end
         end
         S_POW_MUL: begin
            if (mul_done) begin
               state_in = S_POW_SQ;
            end
         end
         S_POW_SQ: begin
            if (mul_done) begin
               state_in = S_POW;
            end
         end
         S_CHK: begin
            state_in = (acc_ff == word_type'(1)) ? S_FIN : S_CHK_LOOP;
         end
         S_CHK_LOOP: begin
            if (b_ff == '0 || acc_ff == p - word_type'(1)) begin
               state_in = S_FIN;
            end else begin
               state_in = S_CHK_SQ;
            end
         end
         S_CHK_SQ: begin
            if (mul_done) begin
               state_in = S_CHK_LOOP;
            end
         end
         S_FIN: begin
            if (!item_ff.last || out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      item_in      = item_ff;
      d_in         = d_ff;
      b_in         = b_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      e_in         = e_ff;
      wit_in       = wit_ff;
      flag_in      = flag_ff;
      wait_in      = wait_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_pp_in    = rsp_pp_ff;
      rsp_load     = 1'b0;
      pop_ready    = 1'b0;
      mm_cmd.start = 1'b0;
      mm_cmd.p     = p;
      mm_cmd.x     = acc_ff;
      mm_cmd.y     = acc_ff;
      case (state_ff)
         S_REDUCE: begin
            mm_cmd.x = word_type'(1);
            mm_cmd.y = item_ff.base;
         end
         S_POW_MUL: begin
            mm_cmd.y = base_ff;
         end
         S_POW_SQ: begin
            mm_cmd.x = base_ff;
            mm_cmd.y = base_ff;
         end
         default: ;
      endcase
      if (mul_state) begin
         if (!wait_ff) begin
            mm_cmd.start = 1'b1;
            wait_in      = 1'b1;
         end else if (mm_rsp.done) begin
            wait_in = 1'b0;
         end
      end
      case (state_ff)
         S_IDLE: begin
            if (pop_valid) begin
               pop_ready = 1'b1;
               item_in   = pop_item;
               d_in      = pop_item.cand - word_type'(1);
               b_in      = '0;
               wit_in    = pop_item.kind == K_COMP;
            end
         end
         S_SHIFT: begin
            if (!d_ff[0]) begin
               d_in = d_ff >> 1;
               b_in = b_ff + SH_W'(1);
            end
         end
         S_REDUCE: begin
            if (mul_done) begin
               base_in = mm_rsp.result;
               acc_in  = word_type'(1);
               e_in    = d_ff;
            end
         end
         S_POW_MUL: begin
            if (mul_done) begin
               acc_in = mm_rsp.result;
            end
         end
         S_POW_SQ: begin
            if (mul_done) begin
               base_in = mm_rsp.result;
               e_in    = e_ff >> 1;
            end
         end
         S_CHK: begin
            if (acc_ff == word_type'(1)) begin
               wit_in = 1'b0;
            end
         end
         S_CHK_LOOP: begin
            if (b_ff == '0) begin
               wit_in = 1'b1;
            end else if (acc_ff == p - word_type'(1)) begin
               wit_in = 1'b0;
            end
         end
         S_CHK_SQ: begin
            if (mul_done) begin
               acc_in = mm_rsp.result;
               b_in   = b_ff - SH_W'(1);
            end
         end
         S_FIN: begin
            if (!item_ff.last) begin
               flag_in = flag_ff || wit_ff;
            end else if (out_free) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_pp_in    = !(flag_ff || wit_ff);
               flag_in      = 1'b0;
            end
         end
         default: ;
      endcase
      rsp.valid          = rsp_valid_ff;
      rsp.probably_prime = rsp_pp_ff;
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      d_ff      <= d_in;
      b_ff      <= b_in;
      base_ff   <= base_in;
      acc_ff    <= acc_in;
      e_ff      <= e_in;
      wit_ff    <= wit_in;
      rsp_pp_ff <= rsp_pp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         flag_ff      <= 1'b0;
         wait_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         flag_ff      <= flag_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `MRPT_ASSERT_NEXT(a_flag_cleared, clock, reset, rsp_load, !flag_ff && rsp_valid_ff)
   `MRPT_ASSERT_IMPL(a_wait_in_mul, clock, reset, wait_ff, mul_state)

endmodule

// ----- dv/tb_miller_rabin_prime_test.sv -----
module tb_miller_rabin_prime_test import mrpt_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   class verdict_board;
      bit composite_seen;
      bit verdicts[$];
      int mismatches;
      int errors;

      function new();
         composite_seen = 0;
         mismatches = 0;
         errors = 0;
      endfunction

      function automatic logic [63:0] mod_mul(logic [63:0] x, logic [63:0] y,
                                              logic [63:0] m);
         return (x * y) % m;
      endfunction

      function automatic logic [63:0] mod_pow(logic [63:0] a, logic [63:0] e,
                                              logic [63:0] m);
         logic [63:0] acc;
         acc = 1 % m;
         a = a % m;
         while (e != 0) begin
            if (e[0]) acc = mod_mul(acc, a, m);
            a = mod_mul(a, a, m);
            e = e >> 1;
         end
         return acc;
      endfunction

      function automatic bit proves_composite(logic [63:0] a, logic [63:0] p);
         logic [63:0] d;
         logic [63:0] x;
         int twos;
         d = p - 1;
         twos = 0;
         while (d[0] == 0) begin
            d = d >> 1;
            twos++;
         end
         x = mod_pow(a, d, p);
         if (x == 1) return 0;
         for (int i = 0; i < twos; i++) begin
            if (x == p - 1) return 0;
            x = mod_mul(x, x, p);
         end
         return 1;
      endfunction

      function void note_base(word_type cand, word_type base, logic last);
         logic [63:0] p;
         p = {33'd0, cand};
         if (p == 2) begin
         end else if (p[0] == 0 || p <= 1) begin
            composite_seen = 1;
         end else if (proves_composite({33'd0, base}, p)) begin
            composite_seen = 1;
         end
         if (last) begin
            verdicts.push_back(!composite_seen);
            composite_seen = 0;
         end
      endfunction

      function void check_verdict(logic got);
         bit want;
         if (verdicts.size() == 0) begin
            errors++;
            if (mismatches++ < 10) $display("unexpected verdict beat: %0b", got);
            return;
         end
         want = verdicts.pop_front();
         if (got !== want) begin
            errors++;
            if (mismatches++ < 10)
               $display("verdict mismatch: expected %0b actual %0b", want, got);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   mrpt_req_if req();
   mrpt_rsp_if rsp();
   verdict_board board;
   bit calm;
   int hold_cycles;

   miller_rabin_prime_test dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   initial begin
      #(8ns * 20000000);
      $display("CHECKS FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready)
            board.note_base(req.candidate, req.base, req.last_base);
         if (rsp.valid && rsp.ready) board.check_verdict(rsp.probably_prime);
      end
   end

   // drain side: random stalls, plus one long hold
   initial begin
      int gap;
      rsp.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_cycles > 0) begin
            rsp.ready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 7);
            rsp.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end else begin
            rsp.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic send_base(word_type cand, word_type base, logic last);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.candidate <= cand;
      req.base <= base;
      req.last_base <= last;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   function automatic word_type rand_word();
      return word_type'($urandom);
   endfunction

   function automatic word_type rand_odd_small();
      return word_type'({$urandom_range(1, 4000), 1'b1});
   endfunction

   initial begin
      word_type cand;
      word_type primes[8];
      int nbases;
      int sel;
      primes = '{31'd3, 31'd5, 31'd7, 31'd97, 31'd7919, 31'd65537,
                 31'd2147483647, 31'd1000003};
      board = new();
      calm = 0;
      hold_cycles = 0;
      reset = 1'b1;
      req.valid = 1'b0;
      req.candidate = '0;
      req.base = '0;
      req.last_base = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_base(31'd2, 31'h7fffffff, 1'b1);
      send_base(31'd0, 31'd5, 1'b1);
      send_base(31'd1, 31'd3, 1'b1);
      send_base(31'd4, 31'd3, 1'b1);
      send_base(31'h7ffffffe, 31'd3, 1'b1);
      send_base(31'd7, 31'd14, 1'b1);
      send_base(31'd7, 31'd1, 1'b1);
      send_base(31'd7, 31'd6, 1'b1);
      send_base(31'd2147483647, 31'd2, 1'b0);
      send_base(31'd2147483647, 31'h7ffffffe, 1'b0);
      send_base(31'd2147483647, 31'h7fffffff, 1'b1);
      send_base(31'd561, 31'd2, 1'b0);
      send_base(31'd561, 31'd5, 1'b1);
      send_base(31'd2047, 31'd2, 1'b1);
      send_base(31'd2047, 31'd3, 1'b1);
      send_base(31'd3, 31'd0, 1'b1);
      send_base(31'd9, 31'd2, 1'b0);
      send_base(31'd2, 31'd2, 1'b1);
      send_base(31'd2, 31'd0, 1'b0);
      send_base(31'd13, 31'd0, 1'b1);

      hold_cycles = 3000;
      for (int i = 0; i < 6; i++)
         send_base(31'd5, word_type'($urandom_range(1, 4)), i == 5);

      for (int n = 0; n < 130; ) begin
         sel = $urandom_range(0, 9);
         if (sel < 4) cand = primes[$urandom_range(0, 7)];
         else if (sel < 7) cand = rand_odd_small();
         else if (sel < 8) cand = rand_word();
         else if (sel < 9) cand = word_type'($urandom_range(0, 4) * 2);
         else cand = word_type'({$urandom_range(1, 100000), 1'b1});
         nbases = $urandom_range(1, 4);
         if (n > 110) calm = 1;
         for (int k = 0; k < nbases; k++) begin
            send_base(cand, ($urandom_range(0, 7) == 0) ? rand_word()
                            : word_type'($urandom_range(0, 200)),
                      k == nbases - 1);
            n++;
         end
      end
      req.valid <= 1'b0;

      while (board.verdicts.size() != 0) @(posedge clock);
      repeat (4000) @(posedge clock);
      if (board.errors == 0 && board.verdicts.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

// ----- files.f -----
+incdir+sv
sv/mrpt_pkg.sv
sv/mrpt_req_if.sv
sv/mrpt_rsp_if.sv
sv/mrpt_front.sv
sv/mrpt_queue.sv
sv/mrpt_modmul.sv
sv/mrpt_back.sv
sv/miller_rabin_prime_test.sv
dv/tb_miller_rabin_prime_test.sv
